### hw/rtl/md5_pkg.sv
// md5_pkg: constants shared by the MD5 hash engine RTL.
// Holds the round constant table, rotate amounts and initial chaining values.
// No dependencies.
package md5_pkg;

  typedef logic [31:0] word_t;

  // Initial chaining values A, B, C, D
  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;

  // Word appended after a full final word: the 1 bit in byte 0
  localparam word_t PAD_WORD = 32'h00000080;

  // Per-round additive constants
  localparam word_t SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round[1:0]}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

### hw/rtl/md5_hash_engine_top.sv
// md5_hash_engine_top: streaming MD5 hash engine, one round unit under a sequencer.
// Depends on md5_pkg for round constants, rotate amounts and initial values.

// A message arrives as little-endian 32-bit words; the word flagged with
// in_tlast ends it and carries 0 to 32 valid bits (bytes in order, bits
// MSB-first within a byte). A non-final word is written into the block buffer
// when taken; the sixteenth of a block also starts a compression: the 64
// rounds through the single round unit, then the chaining add, with
// in_tready low throughout. A final word runs one or two compressions
// plus the padding and length layout steps, and the digest is loaded after
// the last chaining add (later if the previous digest has not yet drained).
// It is loaded into the output register and leaves as two 64-bit words:
// A | B<<32 with tuser 0, then C | D<<32 with tuser 1 and tlast. in_tready
// is high only while the sequencer is idle.
// The next message may start while the digest still waits to be taken.
module md5_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [37:32] valid_bits, [39:38] zero
  input  logic        in_tlast,   // final_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_half
  output logic [0:0]  out_tuser,  // [0] half_index
  output logic        out_tlast   // last_half
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROUND  = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_PAD80  = 3'd3;
  localparam logic [2:0] S_LAYOUT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Where to continue after a compression
  localparam logic [1:0] RET_IDLE   = 2'd0;
  localparam logic [1:0] RET_PAD80  = 2'd1;
  localparam logic [1:0] RET_LAYOUT = 2'd2;
  localparam logic [1:0] RET_DIGEST = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  ret_r, ret_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;

  md5_pkg::word_t cha_r, chb_r, chc_r, chd_r;
  md5_pkg::word_t cha_nxt, chb_nxt, chc_nxt, chd_nxt;
  md5_pkg::word_t wa_r, wb_r, wc_r, wd_r;
  md5_pkg::word_t wa_nxt, wb_nxt, wc_nxt, wd_nxt;

  md5_pkg::word_t buf_r [16];

  // Single buffer write port plus the layout pass
  logic           wr_en;
  logic [3:0]     wr_addr;
  md5_pkg::word_t wr_data;
  logic           layout_en;

  logic           out_valid_r, out_valid_nxt;
  logic           out_half_r, out_half_nxt;
  logic [127:0]   digest_r;
  logic           digest_load;

  // Input word fields
  md5_pkg::word_t in_word;
  logic [5:0]     in_vbits;
  logic [5:0]     vbits_clamp;
  logic           in_fire;

  assign in_word  = in_tdata[31:0];
  assign in_vbits = in_tdata[37:32];
  assign vbits_clamp = (in_vbits > 6'd32) ? 6'd32 : in_vbits;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Final word: keep valid bits, set the 1 bit just after them
  logic [1:0]     pw_bytes;
  logic [2:0]     pw_off;
  logic [4:0]     pw_sh;
  md5_pkg::word_t pw_low, pw_top, pw_one, pad_word;

  always_comb begin
    pw_bytes = vbits_clamp[4:3];
    pw_off   = vbits_clamp[2:0];
    pw_sh    = {pw_bytes, 3'b000};
    pw_low   = (pw_bytes == 2'd0) ? 32'd0 : ((32'd1 << pw_sh) - 32'd1);
    pw_top   = {24'd0, 8'(16'hff00 >> pw_off)};
    pw_one   = {24'd0, 8'(8'h80 >> pw_off)};
    pad_word = (in_word & pw_low)
             | (((in_word >> pw_sh) & pw_top) << pw_sh)
             | (pw_one << pw_sh);
  end

  // Shared round unit
  logic [1:0]     grp;
  logic [3:0]     msg_idx;
  md5_pkg::word_t f_val, sum_val, new_b;
  logic [4:0]     rot;
  logic [63:0]    rot_wide;

  always_comb begin
    grp = round_r[5:4];
    case (grp)
      2'd0: begin
        f_val   = (wb_r & wc_r) | (~wb_r & wd_r);
        msg_idx = round_r[3:0];
      end
      2'd1: begin
        f_val   = (wb_r & wd_r) | (wc_r & ~wd_r);
        msg_idx = 4'(4'd5 * round_r[3:0] + 4'd1);
      end
      2'd2: begin
        f_val   = wb_r ^ wc_r ^ wd_r;
        msg_idx = 4'(4'd3 * round_r[3:0] + 4'd5);
      end
      default: begin
        f_val   = wc_r ^ (wb_r | ~wd_r);
        msg_idx = 4'(4'd7 * round_r[3:0]);
      end
    endcase
    sum_val  = wa_r + f_val + buf_r[msg_idx] + md5_pkg::SINE_K[round_r];
    rot      = md5_pkg::ROT_S[{grp, round_r[1:0]}];
    rot_wide = {sum_val, sum_val} << rot;
    new_b    = wb_r + rot_wide[63:32];
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    round_nxt   = round_r;
    pos_nxt     = pos_r;
    bitcnt_nxt  = bitcnt_r;
    cha_nxt     = cha_r;
    chb_nxt     = chb_r;
    chc_nxt     = chc_r;
    chd_nxt     = chd_r;
    wa_nxt      = wa_r;
    wb_nxt      = wb_r;
    wc_nxt      = wc_r;
    wd_nxt      = wd_r;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = in_word;
    layout_en   = 1'b0;
    digest_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          wr_en   = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_tlast) begin
            bitcnt_nxt = bitcnt_r + 64'd32;
            ret_nxt    = RET_IDLE;
          end else begin
            bitcnt_nxt = bitcnt_r + {58'd0, vbits_clamp};
            if (vbits_clamp != 6'd32) begin
              wr_data = pad_word;
            end
            ret_nxt = (vbits_clamp == 6'd32) ? RET_PAD80 : RET_LAYOUT;
          end
          // Block full: compress; else a final word goes on with the final steps
          if (pos_r == 4'd15) begin
            state_nxt = S_ROUND;
          end else if (in_tlast) begin
            state_nxt = (vbits_clamp == 6'd32) ? S_PAD80 : S_LAYOUT;
          end
        end
      end
      S_PAD80: begin
        wr_en   = 1'b1;
        wr_data = md5_pkg::PAD_WORD;
        pos_nxt = pos_r + 4'd1;
        ret_nxt = RET_LAYOUT;
        state_nxt = (pos_r == 4'd15) ? S_ROUND : S_LAYOUT;
      end
      S_LAYOUT: begin
        if (pos_r == 4'd15) begin
          // No room for the length: zero the last word, run an extra block
          wr_en     = 1'b1;
          wr_addr   = 4'd15;
          wr_data   = '0;
          pos_nxt   = 4'd0;
          ret_nxt   = RET_LAYOUT;
        end else begin
          layout_en = 1'b1;
          ret_nxt   = RET_DIGEST;
        end
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        wa_nxt    = wd_r;
        wd_nxt    = wc_r;
        wc_nxt    = wb_r;
        wb_nxt    = new_b;
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cha_nxt = cha_r + wa_r;
        chb_nxt = chb_r + wb_r;
        chc_nxt = chc_r + wc_r;
        chd_nxt = chd_r + wd_r;
        unique case (ret_r)
          RET_IDLE:   state_nxt = S_IDLE;
          RET_PAD80:  state_nxt = S_PAD80;
          RET_LAYOUT: state_nxt = S_LAYOUT;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        // Wait for the previous digest to drain, then load the digest and restart the chain
        if (!out_valid_r) begin
          digest_load = 1'b1;
          cha_nxt     = md5_pkg::IV_A;
          chb_nxt     = md5_pkg::IV_B;
          chc_nxt     = md5_pkg::IV_C;
          chd_nxt     = md5_pkg::IV_D;
          pos_nxt     = 4'd0;
          bitcnt_nxt  = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the working words from the chain when a compression starts
    if (state_r != S_ROUND && state_nxt == S_ROUND) begin
      round_nxt = '0;
      wa_nxt    = cha_r;
      wb_nxt    = chb_r;
      wc_nxt    = chc_r;
      wd_nxt    = chd_r;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= RET_IDLE;
      round_r  <= '0;
      pos_r    <= '0;
      bitcnt_r <= '0;
      cha_r    <= md5_pkg::IV_A;
      chb_r    <= md5_pkg::IV_B;
      chc_r    <= md5_pkg::IV_C;
      chd_r    <= md5_pkg::IV_D;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      round_r  <= round_nxt;
      pos_r    <= pos_nxt;
      bitcnt_r <= bitcnt_nxt;
      cha_r    <= cha_nxt;
      chb_r    <= chb_nxt;
      chc_r    <= chc_nxt;
      chd_r    <= chd_nxt;
    end
  end

  // Working words
  always_ff @(posedge clk) begin
    wa_r <= wa_nxt;
    wb_r <= wb_nxt;
    wc_r <= wc_nxt;
    wd_r <= wd_nxt;
  end

  // Block buffer: word writes, and the layout pass (zeros, then the length)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (layout_en) begin
        if (i == 14) begin
          buf_r[i] <= bitcnt_r[31:0];
        end else if (i == 15) begin
          buf_r[i] <= bitcnt_r[63:32];
        end else if (4'(i) >= pos_r) begin
          buf_r[i] <= '0;
        end
      end else if (wr_en && wr_addr == 4'(i)) begin
        buf_r[i] <= wr_data;
      end
    end
  end

  // Output register: two digest words
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_half_nxt  = out_half_r;
    if (digest_load) begin
      out_valid_nxt = 1'b1;
      out_half_nxt  = 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (out_half_r) begin
        out_valid_nxt = 1'b0;
      end else begin
        out_half_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_half_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_half_r  <= out_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (digest_load) begin
      digest_r <= {chd_r, chc_r, chb_r, cha_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_half_r ? digest_r[127:64] : digest_r[63:0];
  assign out_tuser[0] = out_half_r;
  assign out_tlast    = out_half_r;

`ifndef NO_ASSERTIONS
  // Last round always hands over to the chaining add
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && round_r == 6'd63) |=> (state_r == S_ADD))
    else $error("round 63 not followed by chaining add");

  // First digest word taken: second one follows at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tuser[0]) |=> (out_tvalid && out_tuser[0]))
    else $error("second digest word missing");

  // Length layout always starts a compression at round zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAYOUT) |=> (state_r == S_ROUND && round_r == 6'd0))
    else $error("layout did not start a compression");

  // Digest hand-off restarts the message state
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=>
      (pos_r == 4'd0 && bitcnt_r == 64'd0 && cha_r == md5_pkg::IV_A))
    else $error("message state not restarted after digest");

  // No word is taken while a compression is running
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> !in_tready)
    else $error("input ready during compression");
`endif

endmodule

### tb/sv/md5_digest_checker.sv
`timescale 1ns / 100ps
// md5_digest_checker: watches the message and digest streams of md5_hash_engine_top,
// predicts each digest from the accepted message words and compares field by field.
// Standalone: keeps its own MD5 round tables and needs nothing from the RTL.
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [37:32] valid_bits, [39:38] zero
  input  logic        in_tlast,   // final_word
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] digest_half
  input  logic [0:0]  out_tuser,  // [0] half_index
  input  logic        out_tlast,  // last_half
  output int          mismatch_count,
  output int          halves_pending,
  output int          halves_checked
);

  localparam logic       HALF_AB        = 1'b0;
  localparam logic       HALF_CD        = 1'b1;
  localparam logic [5:0] FULL_WORD_BITS = 6'd32;
  localparam logic [31:0] PAD_ONE_BIT   = 32'h00000080;

  localparam logic [31:0] INIT_STATE [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // floor(abs(sin(i + 1)) * 2^32)
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left-rotate amounts, four per round group
  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_half;
  } digest_word_t;

  logic [31:0]  hash_state [4];
  logic [31:0]  msg_block [16];
  logic [3:0]   block_fill;
  logic [63:0]  msg_bits;
  digest_word_t expected_halves [$];

  // 64 rounds over msg_block, added into hash_state
  function automatic void run_rounds();
    logic [31:0] a, b, c, d, f, sum;
    int unsigned grp, idx, s;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          idx = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          idx = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          idx = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          idx = (7 * r) % 16;
        end
      endcase
      sum = a + f + msg_block[idx] + ROUND_K[r];
      s = ROUND_SHIFT[grp * 4 + r % 4];
      a = d;
      d = c;
      c = b;
      b = c + ((sum << s) | (sum >> (32 - s)));
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
  endfunction

  function automatic void push_word(input logic [31:0] w);
    msg_block[block_fill] = w;
    block_fill++;
    if (block_fill == 4'd0) run_rounds();
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 4; i++) hash_state[i] = INIT_STATE[i];
    block_fill = '0;
    msg_bits = '0;
  endfunction

  always @(posedge clk) begin : track
    logic [31:0]  w, padded;
    int unsigned  nbits, sh, off;
    digest_word_t want;
    if (!rst_n) begin
      restart_message();
      expected_halves.delete();
    end else begin
      // digest word leaving the block
      if (out_tvalid && out_tready) begin
        if (expected_halves.size() == 0) begin
          $error("unexpected digest word: digest_half %h, half_index %0d, last_half %0d",
                 out_tdata, out_tuser[0], out_tlast);
          mismatch_count++;
        end else begin
          want = expected_halves.pop_front();
          halves_checked++;
          if (out_tdata !== want.digest_half) begin
            $error("digest_half: expected %h, actual %h", want.digest_half, out_tdata);
            mismatch_count++;
          end
          if (out_tuser[0] !== want.half_index) begin
            $error("half_index: expected %0d, actual %0d", want.half_index, out_tuser[0]);
            mismatch_count++;
          end
          if (out_tlast !== want.last_half) begin
            $error("last_half: expected %0d, actual %0d", want.last_half, out_tlast);
            mismatch_count++;
          end
        end
      end

      // message word entering the block
      if (in_tvalid && in_tready) begin
        w = in_tdata[31:0];
        if (!in_tlast) begin
          // body words always count as 32 bits, whatever valid_bits says
          msg_bits += 64'd32;
          push_word(w);
        end else begin
          nbits = (in_tdata[37:32] > FULL_WORD_BITS) ? 32 : in_tdata[37:32];
          msg_bits += nbits;
          if (nbits == 32) begin
            // full last word: the 1 bit opens the next word
            push_word(w);
            push_word(PAD_ONE_BIT);
          end else begin
            // keep whole bytes, the high bits of the partial byte, then the 1 bit
            sh = (nbits / 8) * 8;
            off = nbits % 8;
            padded = (w & ((32'd1 << sh) - 32'd1))
                   | (((w >> sh) & ((32'hff00 >> off) & 32'hff)) << sh)
                   | ((32'h80 >> off) << sh);
            push_word(padded);
          end
          // no room for the length: close this block and start a padding block
          if (block_fill == 4'd15) begin
            msg_block[15] = '0;
            run_rounds();
            block_fill = '0;
          end
          for (int p = block_fill; p < 14; p++) msg_block[p] = '0;
          msg_block[14] = msg_bits[31:0];
          msg_block[15] = msg_bits[63:32];
          run_rounds();
          expected_halves.push_back('{{hash_state[1], hash_state[0]}, HALF_AB, 1'b0});
          expected_halves.push_back('{{hash_state[3], hash_state[2]}, HALF_CD, 1'b1});
          restart_message();
        end
      end
    end
    halves_pending = expected_halves.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives messages into md5_hash_engine_top and takes its digest words,
// with phases of idling and one long receiver hold-off; md5_digest_checker judges.
module tb_top;

  localparam int         ITEM_TARGET    = 900;
  localparam int         HOLD_CYCLES    = 3000;
  localparam int         DRAIN_CYCLES   = 300;
  localparam logic [5:0] FULL_WORD_BITS = 6'd32;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  logic rx_hold        = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   words_sent     = 0;
  int   messages_sent  = 0;
  int   mismatch_count;
  int   halves_pending;
  int   halves_checked;

  always #5 clk = ~clk;

  md5_hash_engine_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  md5_digest_checker i_digest_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .halves_pending (halves_pending),
    .halves_checked (halves_checked)
  );

  // digest receiver: random stalls, or held off entirely
  always @(posedge clk) begin
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long hold-off while words keep coming, so the engine backs up
  initial begin
    wait (words_sent >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #10000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one word, with random idle cycles first; returns at the accepting edge
  task automatic send_word(input logic [31:0] w, input logic [5:0] vbits, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, vbits, w};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic send_message(input int body_words);
    for (int i = 0; i < body_words; i++) begin
      send_word(rand_word(),
                ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : FULL_WORD_BITS, 1'b0);
    end
    send_word(rand_word(),
              ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32)),
              1'b1);
  endtask

  initial begin : stimulus
    int phase;
    int blocks;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message; oversized valid_bits on a last word
    send_word(32'hffff_ffff, 6'd0, 1'b1);
    send_word(32'h0000_0000, 6'd63, 1'b1);
    // body words with odd valid_bits, then a full last word
    send_word(32'hffff_ffff, 6'd0, 1'b0);
    send_word(32'h1234_5678, 6'd63, 1'b0);
    send_word(32'hffff_ffff, FULL_WORD_BITS, 1'b1);
    // three bytes
    send_word(32'h0063_6261, 6'd24, 1'b1);
    // last word lands in slot 14: length spills into a second block
    repeat (14) send_word($urandom, FULL_WORD_BITS, 1'b0);
    send_word(32'hffff_ffff, 6'd17, 1'b1);

    // random messages, mostly under two blocks
    while (words_sent < ITEM_TARGET) begin
      phase = words_sent * 4 / ITEM_TARGET;
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 77;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 77;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct <= 15;
        end
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: blocks = 0;
        6, 7, 8:          blocks = 1;
        default:          blocks = $urandom_range(5, 2);
      endcase
      send_message(16 * blocks + $urandom_range(15));
    end
    in_tvalid <= 1'b0;
    recv_stall_pct <= 0;

    // drain outstanding digests, then watch for strays
    @(posedge clk);
    wait (halves_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: hashed %0d messages from %0d words; %0d digest words compared",
             messages_sent, words_sent, halves_checked);
    if (mismatch_count == 0 && halves_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
